[src/sorted_timer_event_queue_macros.svh]
// assertion helpers included by the queue rtl
`ifndef SORTED_TIMER_EVENT_QUEUE_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_MACROS_SVH

// property checked at every clock edge outside reset
`define STEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property checked in the cycle after a trigger, outside reset
`define STEQ_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

[src/steq_pkg.sv]
`default_nettype none

package steq_pkg;

  // queue size and derived widths
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int STAMP_W   = 32;
  localparam int HANDLER_W = 16;
  localparam int ARG_W     = 32;
  localparam int KIND_W    = 2;

  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  // request codes
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // result codes
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE_DUE = 2'd3;

  // one stored timer entry
  typedef struct packed {
    logic [STAMP_W-1:0]   due;
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     arg;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_TICK,
    ST_DROP
  } steq_state_e;

  // logical slot to ram address in the circular buffer
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] hd,
                                                 input logic [IDX_W-1:0] lidx);
    logic [IDX_W:0] sum;
    logic [IDX_W:0] wrapped;
    sum     = {1'b0, hd} + {1'b0, lidx};
    wrapped = sum - DEPTH_EXT;
    if (sum >= DEPTH_EXT) begin
      phys_addr = wrapped[IDX_W-1:0];
    end else begin
      phys_addr = sum[IDX_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[src/steq_cmd_if.sv]
`default_nettype none

interface steq_cmd_if;
  import steq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [STAMP_W-1:0]   stamp_ms;
  logic [HANDLER_W-1:0] handler_id;
  logic signed [ARG_W-1:0] handler_arg;

  modport source (output valid, command, stamp_ms, handler_id, handler_arg,
                  input ready);
  modport sink (input valid, command, stamp_ms, handler_id, handler_arg,
                output ready);
endinterface

`default_nettype wire

[src/steq_evt_if.sv]
`default_nettype none

interface steq_evt_if;
  import steq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    event_kind;
  logic [HANDLER_W-1:0] out_handler;
  logic signed [ARG_W-1:0] out_arg;
  logic                 last_of_run;

  modport source (output valid, event_kind, out_handler, out_arg, last_of_run,
                  input ready);
  modport sink (input valid, event_kind, out_handler, out_arg, last_of_run,
                output ready);
endinterface

`default_nettype wire

[src/steq_ram.sv]
`default_nettype none

module steq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/sorted_timer_event_queue.sv]
// Sorted timer event queue.
// Requests arrive on cmd_i: command 0 schedules an event (due time, handler,
// argument), command 1 is a tick carrying the current time. Results leave on
// evt_o through one output register; a request is taken only while the block
// is idle, even if an earlier result still waits there.
// Entries live in one RAM used as a circular buffer, sorted by due time with
// the earliest at the head. A schedule walks from the tail toward the head,
// moving one later entry back per cycle, then gives one status result
// (accepted, or dropped when full). A tick pops due entries from the head at
// one RAM read per cycle while the receiver takes results. Each fired entry
// gives one result, the last one marked; with nothing due one status result
// is given. The single RAM read port sets both rates.
// Reset empties the queue at once (entry count and head pointer clear; RAM
// contents are left as they are). When the receiver stalls, the result
// register holds and the block waits with it, losing nothing.
`default_nettype none

module sorted_timer_event_queue (
  input wire logic clk_i,
  input wire logic rst_ni,
  steq_cmd_if.sink   cmd_i,
  steq_evt_if.source evt_o
);
  import steq_pkg::*;

  `include "sorted_timer_event_queue_macros.svh"

  steq_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] hole_q, hole_d;
  logic             pend_valid_q, pend_valid_d;
  entry_t           pend_q, pend_d;
  entry_t           req_q;
  logic             take_req;

  logic                 out_valid_q, out_valid_d;
  logic [KIND_W-1:0]    out_kind_q;
  logic [HANDLER_W-1:0] out_handler_q;
  logic [ARG_W-1:0]     out_arg_q;
  logic                 out_last_q;
  logic                 out_free;

  logic                 emit;
  logic [KIND_W-1:0]    emit_kind;
  logic [HANDLER_W-1:0] emit_handler;
  logic [ARG_W-1:0]     emit_arg;
  logic                 emit_last;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic [CNT_W-1:0] count_m1, hole_m1, hole_m2;
  logic             ins_here, tick_due;

  // entry storage
  steq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign count_m1 = count_q - 1'b1;
  assign hole_m1  = hole_q - 1'b1;
  assign hole_m2  = hole_q - 2'd2;
  assign ins_here = (hole_q == '0) || (ram_rdata.due <= req_q.due);
  assign tick_due = (count_q != '0) && (ram_rdata.due <= req_q.due);
  assign out_free = !out_valid_q || evt_o.ready;

  // next state, ram access and result selection
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    hole_d       = hole_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    take_req     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = phys_addr(head_q, hole_q[IDX_W-1:0]);
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = head_q;
    emit         = 1'b0;
    emit_kind    = KIND_ACCEPTED;
    emit_handler = '0;
    emit_arg     = '0;
    emit_last    = 1'b1;
    cmd_i.ready  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.valid) begin
          take_req = 1'b1;
          if (cmd_i.command == CMD_TICK) begin
            ram_re       = 1'b1;
            ram_raddr    = head_q;
            pend_valid_d = 1'b0;
            state_d      = ST_TICK;
          end else if (count_q == DEPTH_CNT) begin
            state_d = ST_DROP;
          end else begin
            hole_d    = count_q;
            ram_re    = (count_q != '0);
            ram_raddr = phys_addr(head_q, count_m1[IDX_W-1:0]);
            state_d   = ST_INS;
          end
        end
      end

      ST_INS: begin
        if (ins_here) begin
          // place the new entry into the hole
          if (out_free) begin
            ram_we    = 1'b1;
            ram_wdata = req_q;
            count_d   = count_q + 1'b1;
            emit      = 1'b1;
            emit_kind = KIND_ACCEPTED;
            state_d   = ST_IDLE;
          end
        end else begin
          // later entry moves back one slot, hole moves toward the head
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          hole_d    = hole_m1;
          ram_re    = (hole_q >= CNT_W'(2));
          ram_raddr = phys_addr(head_q, hole_m2[IDX_W-1:0]);
        end
      end

      ST_TICK: begin
        if (tick_due) begin
          // pop the head; the held entry goes out as a non-final result
          if (!pend_valid_q || out_free) begin
            emit         = pend_valid_q;
            emit_kind    = KIND_FIRED;
            emit_handler = pend_q.handler;
            emit_arg     = pend_q.arg;
            emit_last    = 1'b0;
            pend_d       = ram_rdata;
            pend_valid_d = 1'b1;
            head_d       = phys_addr(head_q, IDX_W'(1));
            count_d      = count_m1;
            ram_re       = (count_q > CNT_W'(1));
            ram_raddr    = phys_addr(head_q, IDX_W'(1));
          end
        end else if (out_free) begin
          // end of run
          emit = 1'b1;
          if (pend_valid_q) begin
            emit_kind    = KIND_FIRED;
            emit_handler = pend_q.handler;
            emit_arg     = pend_q.arg;
          end else begin
            emit_kind = KIND_NONE_DUE;
          end
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      ST_DROP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_DROPPED;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && !evt_o.ready);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      head_q       <= '0;
      hole_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      head_q       <= head_d;
      hole_q       <= hole_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (take_req) begin
      req_q.due     <= cmd_i.stamp_ms;
      req_q.handler <= cmd_i.handler_id;
      req_q.arg     <= cmd_i.handler_arg;
    end
    if (emit) begin
      out_kind_q    <= emit_kind;
      out_handler_q <= emit_handler;
      out_arg_q     <= emit_arg;
      out_last_q    <= emit_last;
    end
  end

  // result channel
  assign evt_o.valid       = out_valid_q;
  assign evt_o.event_kind  = out_kind_q;
  assign evt_o.out_handler = out_handler_q;
  assign evt_o.out_arg     = out_arg_q;
  assign evt_o.last_of_run = out_last_q;

  // checks
  `STEQ_ASSERT(a_count_bound, (count_q <= DEPTH_CNT), "entry count above queue depth")
  `STEQ_ASSERT(a_hole_bound, (state_q == ST_INS) |-> (hole_q <= count_q), "hole past tail")
  `STEQ_ASSERT(a_run_open, (out_valid_q && (out_kind_q == KIND_FIRED) && !out_last_q) |-> (state_q == ST_TICK), "open run outside tick")
  `STEQ_ASSERT_NEXT(a_ins_count, (state_q == ST_INS) && (state_d == ST_IDLE), (count_q == $past(count_q) + 1'b1), "insert did not grow queue")

endmodule

`default_nettype wire
